[rtl/lpr_pkg.sv]
// Package: types, constants and helpers shared by the longest-prefix router.
package lpr_pkg;

  // Table size and field widths
  localparam int ROUTES   = 32;
  localparam int ADDR_W   = (ROUTES > 1) ? $clog2(ROUTES) : 1;
  localparam int CNT_W    = $clog2(ROUTES + 1);
  localparam int IP_W     = 32;
  localparam int LEN_W    = 6;
  localparam int IFACE_W  = 3;
  localparam int TTL_W    = 8;
  localparam int STATUS_W = 3;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(IP_W);

  // Command codes
  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED    = 3'd0,
    ST_FULL     = 3'd1,
    ST_FORWARD  = 3'd2,
    ST_TTL_DROP = 3'd3,
    ST_NO_ROUTE = 3'd4
  } status_t;

  // Control sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_LOAD
  } state_t;

  // Input transaction
  typedef struct packed {
    logic               command;
    logic [IP_W-1:0]    net_prefix;
    logic [LEN_W-1:0]   prefix_len;
    logic               has_next_hop;
    logic [IP_W-1:0]    gateway_addr;
    logic [IFACE_W-1:0] iface_index;
    logic [IP_W-1:0]    dest_addr;
    logic [TTL_W-1:0]   ttl_in;
  } req_t;

  // Result transaction
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IFACE_W-1:0]  out_iface;
    logic [IP_W-1:0]     hop_addr;
    logic [TTL_W-1:0]    ttl_out;
  } rsp_t;

  // One stored route
  typedef struct packed {
    logic [IP_W-1:0]    prefix;
    logic [LEN_W-1:0]   len;
    logic               gw_valid;
    logic [IP_W-1:0]    gw;
    logic [IFACE_W-1:0] iface;
  } entry_t;

  // Outcome of a table scan
  typedef struct packed {
    logic               found;
    logic [IFACE_W-1:0] iface;
    logic [IP_W-1:0]    hop;
  } scan_res_t;

  // High-order mask of len ones; a length of zero gives an empty mask
  function automatic logic [IP_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] sh;
    sh = MAX_LEN - len;
    return {IP_W{1'b1}} << sh;
  endfunction

endpackage

[rtl/lpr_if.sv]
// Interfaces: valid/ready channels for request and result transactions.
interface lpr_req_if;
  logic          valid;
  logic          ready;
  lpr_pkg::req_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

interface lpr_rsp_if;
  logic          valid;
  logic          ready;
  lpr_pkg::rsp_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

[rtl/ipv4_longest_prefix_router.sv]
// An add or a low-TTL drop goes from S_IDLE to S_EXEC, which loads its result into the
// output register; a lookup goes on to the one-route-per-cycle scan in S_SCAN, then S_LOAD.
// One transaction at a time; the next is accepted once the previous one is
// finished, while its result may still wait in the output register.
// Reset (synchronous, active high) empties the table by clearing the route count; the
// route RAM itself is not cleared, entries are read only after they are written.
module ipv4_longest_prefix_router (
  input  logic          clk,
  input  logic          rst,
  lpr_req_if.sink       req,
  lpr_rsp_if.source     rsp
);

  lpr_pkg::state_t                state;
  lpr_pkg::state_t                state_next;
  lpr_pkg::req_t                  item;
  logic [lpr_pkg::CNT_W-1:0]      count;
  logic                           full;
  logic                           slot_free;
  logic                           accept;
  logic                           ram_we;
  lpr_pkg::entry_t                wr_entry;
  logic                           ram_re;
  logic [lpr_pkg::ADDR_W-1:0]     ram_raddr;
  lpr_pkg::entry_t                ram_rdata;
  logic                           scan_start;
  logic                           scan_done;
  lpr_pkg::scan_res_t             scan_res;
  logic                           load;
  lpr_pkg::rsp_t                  out_next;
  logic                           rsp_valid;
  lpr_pkg::rsp_t                  rsp_data;

  assign full      = (count == lpr_pkg::CNT_W'(lpr_pkg::ROUTES));
  assign slot_free = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  // Build the route written by an add
  assign wr_entry.prefix   = item.net_prefix;
  assign wr_entry.len      = item.prefix_len;
  assign wr_entry.gw_valid = item.has_next_hop;
  assign wr_entry.gw       = item.gateway_addr;
  assign wr_entry.iface    = item.iface_index;

  lpr_ram #(
    .WIDTH ($bits(lpr_pkg::entry_t)),
    .DEPTH (lpr_pkg::ROUTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[lpr_pkg::ADDR_W-1:0]),
    .wdata (wr_entry),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lpr_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .start     (scan_start),
    .count     (count),
    .dest      (item.dest_addr),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .done      (scan_done),
    .result    (scan_res)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      lpr_pkg::S_IDLE: begin
        if (accept) begin
          state_next = lpr_pkg::S_EXEC;
        end
      end
      lpr_pkg::S_EXEC: begin
        if (item.command == lpr_pkg::CMD_LOOKUP && item.ttl_in > 8'd1) begin
          state_next = lpr_pkg::S_SCAN;
        end else if (slot_free) begin
          state_next = lpr_pkg::S_IDLE;
        end
      end
      lpr_pkg::S_SCAN: begin
        if (scan_done) begin
          state_next = lpr_pkg::S_LOAD;
        end
      end
      lpr_pkg::S_LOAD: begin
        if (slot_free) begin
          state_next = lpr_pkg::S_IDLE;
        end
      end
      default: state_next = lpr_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    req.ready  = 1'b0;
    ram_we     = 1'b0;
    scan_start = 1'b0;
    load       = 1'b0;
    out_next   = '0;
    case (state)
      lpr_pkg::S_IDLE: begin
        req.ready = 1'b1;
      end
      lpr_pkg::S_EXEC: begin
        if (item.command == lpr_pkg::CMD_ADD) begin
          load = slot_free;
          if (full) begin
            out_next.status = lpr_pkg::ST_FULL;
          end else begin
            ram_we          = slot_free;
            out_next.status = lpr_pkg::ST_ADDED;
          end
        end else if (item.ttl_in <= 8'd1) begin
          load            = slot_free;
          out_next.status = lpr_pkg::ST_TTL_DROP;
        end else begin
          scan_start = 1'b1;
        end
      end
      lpr_pkg::S_LOAD: begin
        load = slot_free;
        if (scan_res.found) begin
          out_next.status    = lpr_pkg::ST_FORWARD;
          out_next.out_iface = scan_res.iface;
          out_next.hop_addr  = scan_res.hop;
          out_next.ttl_out   = item.ttl_in - 1'b1;
        end else begin
          out_next.status = lpr_pkg::ST_NO_ROUTE;
        end
      end
      default: begin
      end
    endcase
  end

  // State, route count and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lpr_pkg::S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ram_we) begin
        count <= count + 1'b1;
      end
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Hold the accepted transaction and the pending result
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= req.payload;
    end
    if (load) begin
      rsp_data <= out_next;
    end
  end

  assign rsp.valid   = rsp_valid;
  assign rsp.payload = rsp_data;

endmodule

[rtl/lpr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/lpr_scan.sv]
// Table scanner: reads one route per cycle and keeps the longest match.
module lpr_scan (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [lpr_pkg::CNT_W-1:0]    count,
  input  logic [lpr_pkg::IP_W-1:0]     dest,
  output logic                         ram_re,
  output logic [lpr_pkg::ADDR_W-1:0]   ram_raddr,
  input  lpr_pkg::entry_t              ram_rdata,
  output logic                         done,
  output lpr_pkg::scan_res_t           result
);

  logic                           busy;
  logic                           pend;
  logic [lpr_pkg::CNT_W-1:0]      rd_ptr;
  logic [lpr_pkg::IP_W-1:0]       dest_q;
  logic                           found;
  logic [lpr_pkg::LEN_W-1:0]      best_len;
  logic                           best_gw_valid;
  logic [lpr_pkg::IP_W-1:0]       best_gw;
  logic [lpr_pkg::IFACE_W-1:0]    best_iface;
  logic [lpr_pkg::IP_W-1:0]       mask;
  logic                           hit;
  logic                           better;
  logic                           more;

  // Issue reads until every stored route has been requested
  assign more      = (rd_ptr != count);
  assign ram_re    = busy && more;
  assign ram_raddr = rd_ptr[lpr_pkg::ADDR_W-1:0];
  assign done      = busy && !more && !pend;

  // Compare the entry that came back from the RAM
  always_comb begin
    mask   = lpr_pkg::prefix_mask(ram_rdata.len);
    hit    = (ram_rdata.len <= lpr_pkg::MAX_LEN) &&
             ((dest_q & mask) == (ram_rdata.prefix & mask));
    better = !found || (best_len < ram_rdata.len);
  end

  // Sequence the scan
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      pend   <= 1'b0;
      rd_ptr <= '0;
      found  <= 1'b0;
    end else if (start) begin
      busy   <= 1'b1;
      pend   <= 1'b0;
      rd_ptr <= '0;
      found  <= 1'b0;
    end else if (busy) begin
      pend <= more;
      if (more) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (pend && hit && better) begin
        found <= 1'b1;
      end
      if (done) begin
        busy <= 1'b0;
      end
    end
  end

  // Hold the best route so far
  always_ff @(posedge clk) begin
    if (start) begin
      dest_q <= dest;
    end
    if (busy && pend && hit && better) begin
      best_len      <= ram_rdata.len;
      best_gw_valid <= ram_rdata.gw_valid;
      best_gw       <= ram_rdata.gw;
      best_iface    <= ram_rdata.iface;
    end
  end

  // Direct routes send to the destination itself
  assign result.found = found;
  assign result.iface = best_iface;
  assign result.hop   = best_gw_valid ? best_gw : dest_q;

endmodule

[sim/tb_ipv4_longest_prefix_router.sv]
// Testbench for the longest-prefix router: directed and random route and lookup traffic.
`timescale 1ns / 1ps

module tb_ipv4_longest_prefix_router;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = lpr_pkg::ROUTES + 40;
  localparam int MAX_REPORTS  = 10;
  localparam int REQ_W        = $bits(lpr_pkg::req_t);

  logic clk;
  logic rst = 1'b1;

  lpr_req_if req_bus();
  lpr_rsp_if rsp_bus();

  ipv4_longest_prefix_router i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  // Route table as the testbench sees it
  lpr_pkg::entry_t route_tab[lpr_pkg::ROUTES];
  int unsigned     route_count = 0;

  // Results still to arrive, oldest first
  lpr_pkg::rsp_t   route_expect[$];

  int unsigned send_idle_pct = 8;
  int unsigned rcv_stall_pct = 69;
  int unsigned fail_count    = 0;
  int unsigned cycle_count   = 0;

  // Generate the clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               route_expect.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // High-order mask for a prefix length; lengths above 32 compare every bit
  function automatic logic [lpr_pkg::IP_W-1:0] len_mask(
    input logic [lpr_pkg::LEN_W-1:0] len);
    if (len == '0) begin
      return '0;
    end
    if (len > lpr_pkg::MAX_LEN) begin
      return '1;
    end
    return {lpr_pkg::IP_W{1'b1}} << (lpr_pkg::IP_W - int'(len));
  endfunction

  function automatic bit route_hit(input logic [lpr_pkg::IP_W-1:0] addr,
                                   input lpr_pkg::entry_t e);
    if (e.len > lpr_pkg::MAX_LEN) begin
      return 1'b0;
    end
    return ((addr ^ e.prefix) & len_mask(e.len)) == '0;
  endfunction

  // Update the table and work out the result of one transaction
  function automatic lpr_pkg::rsp_t predict_route(input lpr_pkg::req_t item);
    lpr_pkg::rsp_t r;
    int            best;
    r    = '0;
    best = -1;
    if (item.command == lpr_pkg::CMD_ADD) begin
      if (route_count >= lpr_pkg::ROUTES) begin
        r.status = lpr_pkg::ST_FULL;
      end else begin
        route_tab[route_count] = '{prefix: item.net_prefix, len: item.prefix_len,
                                   gw_valid: item.has_next_hop, gw: item.gateway_addr,
                                   iface: item.iface_index};
        route_count++;
        r.status = lpr_pkg::ST_ADDED;
      end
    end else if (item.ttl_in <= 1) begin
      r.status = lpr_pkg::ST_TTL_DROP;
    end else begin
      // Keep the earliest route among the longest matches
      for (int i = 0; i < int'(route_count); i++) begin
        if (route_hit(item.dest_addr, route_tab[i])) begin
          if (best < 0 || route_tab[best].len < route_tab[i].len) begin
            best = i;
          end
        end
      end
      if (best < 0) begin
        r.status = lpr_pkg::ST_NO_ROUTE;
      end else begin
        r.status    = lpr_pkg::ST_FORWARD;
        r.out_iface = route_tab[best].iface;
        r.hop_addr  = route_tab[best].gw_valid ? route_tab[best].gw : item.dest_addr;
        r.ttl_out   = item.ttl_in - 1'b1;
      end
    end
    return r;
  endfunction

  task automatic note_failure(input string what, input lpr_pkg::rsp_t want,
                              input lpr_pkg::rsp_t got);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("ERROR %0t: %s: expected status=%0d iface=%0d hop=%h ttl=%0d,",
               $realtime, what, want.status, want.out_iface, want.hop_addr,
               want.ttl_out);
      $display("  got status=%0d iface=%0d hop=%h ttl=%0d",
               got.status, got.out_iface, got.hop_addr, got.ttl_out);
    end
  endtask

  // Drive the result ready with random stalls
  always @(posedge clk) begin
    rsp_bus.ready <= ($urandom_range(99) >= rcv_stall_pct);
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin : check_results
    lpr_pkg::rsp_t want;
    lpr_pkg::rsp_t got;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      got = rsp_bus.payload;
      if (route_expect.size() == 0) begin
        note_failure("unexpected result", '0, got);
      end else begin
        want = route_expect.pop_front();
        if (got.status != want.status || got.out_iface != want.out_iface ||
            got.hop_addr != want.hop_addr || got.ttl_out != want.ttl_out) begin
          note_failure("result mismatch", want, got);
        end
      end
    end
  end

  // Send one request transaction; valid stays high unless the sender idles
  task automatic send_item(input lpr_pkg::req_t item);
    if ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    req_bus.valid   <= 1'b1;
    req_bus.payload <= item;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    route_expect.push_back(predict_route(item));
  endtask

  // Fields that the command ignores carry random values
  task automatic install_route(input logic [lpr_pkg::IP_W-1:0] pfx,
                               input logic [lpr_pkg::LEN_W-1:0] len,
                               input logic gw_valid,
                               input logic [lpr_pkg::IP_W-1:0] gw,
                               input logic [lpr_pkg::IFACE_W-1:0] iface);
    lpr_pkg::req_t item;
    item              = REQ_W'({$urandom, $urandom, $urandom, $urandom});
    item.command      = lpr_pkg::CMD_ADD;
    item.net_prefix   = pfx;
    item.prefix_len   = len;
    item.has_next_hop = gw_valid;
    item.gateway_addr = gw;
    item.iface_index  = iface;
    send_item(item);
  endtask

  task automatic lookup(input logic [lpr_pkg::IP_W-1:0] dest,
                        input logic [lpr_pkg::TTL_W-1:0] ttl);
    lpr_pkg::req_t item;
    item           = REQ_W'({$urandom, $urandom, $urandom, $urandom});
    item.command   = lpr_pkg::CMD_LOOKUP;
    item.dest_addr = dest;
    item.ttl_in    = ttl;
    send_item(item);
  endtask

  // Empty table: no route, and low TTL drops
  task automatic test_empty_table();
    lookup(32'h0000_0000, 8'd2);
    lookup(32'hffff_ffff, 8'd255);
    lookup($urandom, 8'd0);
    lookup($urandom, 8'd1);
  endtask

  // Lengths above 32 are stored but never match
  task automatic test_overlong_prefix();
    install_route(32'h0000_0000, 6'd33, 1'b1, 32'h0102_0304, 3'd4);
    install_route(32'hffff_ffff, 6'd63, 1'b0, 32'hffff_ffff, 3'd7);
    lookup(32'h0000_0000, 8'd64);
    lookup(32'hffff_ffff, 8'd255);
  endtask

  // Full-length host route through a gateway
  task automatic test_host_route();
    install_route(32'hc0a8_0101, 6'd32, 1'b1, 32'h0a00_0001, 3'd7);
    lookup(32'hc0a8_0101, 8'd255);
    lookup(32'hc0a8_0100, 8'd100);
  endtask

  // Longer prefix wins; equal lengths keep the earliest route
  task automatic test_longest_match();
    install_route(32'h0a00_0000, 6'd8, 1'b0, 32'hdead_beef, 3'd1);
    install_route(32'h0a01_0000, 6'd16, 1'b1, 32'h0a00_00fe, 3'd2);
    install_route(32'h0a01_ffff, 6'd16, 1'b1, 32'h0a00_00fd, 3'd3);
    install_route(32'h0a01_0200, 6'd24, 1'b0, 32'h0000_0000, 3'd0);
    lookup(32'h0a01_0203, 8'd2);
    lookup(32'h0a01_ff00, 8'd128);
    lookup(32'h0a7f_0000, 8'd33);
    lookup(32'h0b00_0000, 8'd77);
  endtask

  // Zero-length default route catches everything else
  task automatic test_default_route();
    install_route(32'h5a5a_5a5a, 6'd0, 1'b1, 32'hc0a8_00fe, 3'd5);
    lookup(32'h0b00_0000, 8'd200);
    lookup(32'h0a01_0203, 8'd9);
  endtask

  // Mostly lookups aimed at stored prefixes, some nested adds, some noise
  task automatic test_random_traffic(input int unsigned n_items);
    lpr_pkg::entry_t                near_e;
    logic [lpr_pkg::IP_W-1:0]       m;
    logic [lpr_pkg::IP_W-1:0]       addr;
    logic [lpr_pkg::LEN_W-1:0]      len;
    logic [lpr_pkg::TTL_W-1:0]      ttl;
    int unsigned                    pick;
    int unsigned                    lpick;
    for (int unsigned n = 0; n < n_items; n++) begin
      pick = $urandom_range(99);
      addr = $urandom;
      if (pick < 12) begin
        lpick = $urandom_range(99);
        if (lpick < 4) begin
          len = lpr_pkg::LEN_W'($urandom_range(63, 33));
        end else if (lpick < 7) begin
          len = '0;
        end else begin
          len = lpr_pkg::LEN_W'($urandom_range(32, 1));
        end
        // Nest half the new routes inside an existing prefix
        if (route_count != 0 && $urandom_range(1) == 1) begin
          near_e = route_tab[$urandom_range(route_count - 1)];
          m      = len_mask(near_e.len);
          addr   = (near_e.prefix & m) | (addr & ~m);
        end
        install_route(addr, len, 1'($urandom), $urandom,
                      lpr_pkg::IFACE_W'($urandom));
      end else if (pick < 20) begin
        lookup(addr, lpr_pkg::TTL_W'($urandom_range(255)));
      end else begin
        // Aim at a stored prefix, sometimes one bit off
        if (route_count != 0) begin
          near_e = route_tab[$urandom_range(route_count - 1)];
          m      = len_mask(near_e.len);
          addr   = (near_e.prefix & m) | (addr & ~m);
          if ($urandom_range(3) == 0) begin
            addr = addr ^ (32'h1 << $urandom_range(31));
          end
        end
        ttl = ($urandom_range(9) == 0) ? lpr_pkg::TTL_W'($urandom_range(1)) :
                                         lpr_pkg::TTL_W'($urandom_range(255, 2));
        lookup(addr, ttl);
      end
    end
  endtask

  initial begin
    req_bus.valid   = 1'b0;
    req_bus.payload = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Sender mostly busy, receiver stalls often
    send_idle_pct = 8;
    rcv_stall_pct = 69;
    test_empty_table();
    test_overlong_prefix();
    test_host_route();
    test_longest_match();
    test_default_route();
    test_random_traffic(460);

    // Sender idles often, receiver mostly ready
    send_idle_pct = 69;
    rcv_stall_pct = 8;
    test_random_traffic(470);

    // Back to back
    send_idle_pct = 0;
    rcv_stall_pct = 0;
    test_random_traffic(470);

    // Drain outstanding results, then watch for stray ones
    req_bus.valid <= 1'b0;
    while (route_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
